// File: rtl/core/stl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package stl_pkg;

   localparam int SlotsDefault = 2;
   localparam int SlotIdW      = 4;

   localparam logic [31:0] IdleTimeoutReset = 32'd1800000;
   localparam logic [31:0] AbsTimeoutReset  = 32'd28800000;
   localparam logic [31:0] LockDurationReset = 32'd30000;
   localparam logic [7:0]  FailureLimitReset = 8'd5;

   // Seconds are found by a multiply with 2^38 / 1000 rounded up and a shift by 38,
   // which is exact for every 32-bit dividend.
   localparam logic [31:0] RoundC     = 32'd999;
   localparam logic [28:0] RecipC     = 29'd274877907;
   localparam int          RecipShift = 38;

   typedef enum logic [2:0] {
      KindCheck  = 3'd0,
      KindCsrf   = 3'd1,
      KindLogin  = 3'd2,
      KindLogout = 3'd3,
      KindInvAll = 3'd4
   } kind_type;

   typedef enum logic [2:0] {
      StatusOk      = 3'd0,
      StatusUnauth  = 3'd1,
      StatusCsrfBad = 3'd2,
      StatusLocked  = 3'd3,
      StatusBadCred = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      CsrIdleTimeout  = 2'd0,
      CsrAbsTimeout   = 2'd1,
      CsrLockDuration = 2'd2,
      CsrFailureLimit = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      StIdle,
      StDispatch,
      StScan,
      StDiv
   } state_type;

   typedef enum logic {
      ModeFind,
      ModePick
   } scan_mode_type;

   typedef struct packed {
      logic [31:0] now;
      logic [31:0] addr;
      logic [63:0] token_high;
      logic [63:0] token_low;
      logic [31:0] csrf_high;
      logic [63:0] csrf_low;
   } req_type;

   typedef struct packed {
      logic               wr_en;
      logic [SlotIdW-1:0] wr_slot;
      logic               clr_all;
      logic [31:0]        idle_timeout;
      logic [31:0]        abs_timeout;
   } ctl_type;

   typedef struct packed {
      logic               valid;
      scan_mode_type      mode;
      logic               touch;
      logic               logout;
      logic               found;
      logic [SlotIdW-1:0] found_slot;
      logic [31:0]        csrf_high;
      logic [63:0]        csrf_low;
      logic               free_found;
      logic [SlotIdW-1:0] free_slot;
      logic [SlotIdW-1:0] best_slot;
      logic [31:0]        best_seen;
   } tok_type;

endpackage

`default_nettype wire

// File: rtl/core/stl_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module stl_cell #(
   parameter int Idx = 0
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire stl_pkg::req_type req,
   input  wire stl_pkg::ctl_type ctl,
   input  wire stl_pkg::tok_type tok_i,
   output stl_pkg::tok_type      tok_o
);

   localparam logic [stl_pkg::SlotIdW-1:0] CellId = stl_pkg::SlotIdW'(Idx);

   logic        active_ff, active_in;
   logic [31:0] created_ff, created_in;
   logic [31:0] seen_ff, seen_in;
   logic [63:0] token_high_ff, token_low_ff, csrf_low_ff;
   logic [31:0] csrf_high_ff, addr_ff;
   stl_pkg::tok_type tok_ff, tok_in;

   logic        expired, match, wr_here;
   logic [31:0] idle_age, abs_age, seen_diff;

   assign idle_age  = req.now - seen_ff;
   assign abs_age   = req.now - created_ff;
   assign expired   = (idle_age > ctl.idle_timeout) || (abs_age > ctl.abs_timeout);
   assign match     = (addr_ff == req.addr) && (token_high_ff == req.token_high) &&
                      (token_low_ff == req.token_low);
   assign seen_diff = seen_ff - tok_i.best_seen;
   assign wr_here   = ctl.wr_en && (ctl.wr_slot == CellId);

   always_comb begin
      tok_in     = tok_i;
      active_in  = active_ff;
      seen_in    = seen_ff;
      created_in = created_ff;
      if (tok_i.valid) begin
         if (tok_i.mode == stl_pkg::ModeFind) begin
            // The scan stops at the first hit, so later slots are left alone.
            if (!tok_i.found && active_ff) begin
               if (expired) begin
                  active_in = 1'b0;
               end else if (match) begin
                  tok_in.found      = 1'b1;
                  tok_in.found_slot = CellId;
                  tok_in.csrf_high  = csrf_high_ff;
                  tok_in.csrf_low   = csrf_low_ff;
                  if (tok_i.touch) seen_in = req.now;
                  if (tok_i.logout) active_in = 1'b0;
               end
            end
         end else begin
            if (!tok_i.free_found && (!active_ff || expired)) begin
               tok_in.free_found = 1'b1;
               tok_in.free_slot  = CellId;
            end
            if (Idx == 0 || seen_diff[31]) begin
               tok_in.best_slot = CellId;
               tok_in.best_seen = seen_ff;
            end
         end
      end
      if (ctl.clr_all) active_in = 1'b0;
      if (wr_here) begin
         active_in  = 1'b1;
         created_in = req.now;
         seen_in    = req.now;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff  <= 1'b0;
         created_ff <= '0;
         seen_ff    <= '0;
         tok_ff     <= '0;
      end else begin
         active_ff  <= active_in;
         created_ff <= created_in;
         seen_ff    <= seen_in;
         tok_ff     <= tok_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_here) begin
         token_high_ff <= req.token_high;
         token_low_ff  <= req.token_low;
         csrf_high_ff  <= req.csrf_high;
         csrf_low_ff   <= req.csrf_low;
         addr_ff       <= req.addr;
      end
   end

   assign tok_o = tok_ff;

endmodule

`default_nettype wire

// File: rtl/core/stl_div.sv
`timescale 1ns / 1ps
`default_nettype none

module stl_div (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [31:0] dividend,
   output logic             done,
   output logic [22:0]      quotient
);

   logic        run_ff, run_in;
   logic        done_ff, done_in;
   logic [31:0] x_ff, x_in;
   logic [22:0] q_ff, q_in;
   logic [60:0] product;

   // The dividend is registered first so the multiply runs from that register into the quotient register.
   assign product = 61'(x_ff) * 61'(stl_pkg::RecipC);

   always_comb begin
      run_in  = start;
      done_in = run_ff;
      x_in    = x_ff;
      q_in    = q_ff;
      if (start) x_in = dividend;
      if (run_ff) q_in = product[stl_pkg::RecipShift +: 23];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      q_ff <= q_in;
   end

   assign done     = done_ff;
   assign quotient = q_ff;

endmodule

`default_nettype wire

// File: rtl/core/session_table_with_login_lockout.sv
`timescale 1ns / 1ps
`default_nettype none

// Session store with login lockout.
// Requests: drive the req_ ports and raise start; the item is taken at an edge
// where start is high and busy is low. busy stays high until the result is out.
// Results: rsp_valid is high for exactly one cycle with rsp_status, rsp_slot,
// rsp_retry_seconds and the session csrf; the receiver cannot stall, so it must
// take the result in that cycle. The next item may start in the cycle the
// result is shown. Requests without a scan (missing token, invalidate all, failed
// login, unknown kind) answer from the dispatch state; lookups, logouts and
// successful logins wait for the token walking the chain of slot cells one cell a
// cycle, and a locked login waits for the registered reciprocal multiply that
// rounds the remaining lock time up to seconds.
// Items are handled one at a time.
// Configuration: csr_ready is always high; write only while busy is low.
// Reset (synchronous) clears all sessions, the failure count and the lock and loads
// the default timeouts, lock duration and failure limit; there is no clearing pass.
module session_table_with_login_lockout #(
   parameter int SESSION_SLOTS = stl_pkg::SlotsDefault
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   output logic              busy,
   input  wire logic [2:0]   req_kind,
   input  wire logic [31:0]  req_now,
   input  wire logic [31:0]  req_client_address,
   input  wire logic [63:0]  req_token_high,
   input  wire logic [63:0]  req_token_low,
   input  wire logic         req_token_present,
   input  wire logic [31:0]  req_csrf_high,
   input  wire logic [63:0]  req_csrf_low,
   input  wire logic         req_csrf_present,
   input  wire logic         req_credentials_match,
   output logic              rsp_valid,
   output logic [2:0]        rsp_status,
   output logic              rsp_slot,
   output logic [22:0]       rsp_retry_seconds,
   output logic [31:0]       rsp_session_csrf_high,
   output logic [63:0]       rsp_session_csrf_low,
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [1:0]   csr_index,
   input  wire logic [31:0]  csr_data
);

   stl_pkg::state_type state_ff, state_in;
   stl_pkg::req_type   req_ff;
   logic [2:0]         kind_ff;
   logic               tok_ok_ff, csrf_ok_ff, cred_ff;

   logic [31:0] idle_ff, abs_ff, lock_dur_ff;
   logic [7:0]  limit_ff;
   logic [7:0]  fail_ff, fail_in;
   logic [31:0] lu_ff, lu_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [2:0]  rsp_status_ff, rsp_status_in;
   logic        rsp_slot_ff, rsp_slot_in;
   logic [22:0] rsp_retry_ff, rsp_retry_in;
   logic [31:0] rsp_ch_ff, rsp_ch_in;
   logic [63:0] rsp_cl_ff, rsp_cl_in;

   stl_pkg::tok_type chain [0:SESSION_SLOTS];
   stl_pkg::tok_type launch, tail;
   stl_pkg::ctl_type ctl;

   logic        div_start, div_done;
   logic [22:0] div_q;
   logic [31:0] left, fail_inc, lock_end;
   logic        locked;
   logic [stl_pkg::SlotIdW-1:0] chosen;

   assign left     = lu_ff - req_ff.now;
   assign locked   = (lu_ff != '0) && (left != '0) && !left[31];
   assign fail_inc = {24'd0, fail_ff + 8'd1};
   assign lock_end = req_ff.now + lock_dur_ff;
   assign tail     = chain[SESSION_SLOTS];
   assign chosen   = tail.free_found ? tail.free_slot : tail.best_slot;
   assign chain[0] = launch;

   genvar g;
   generate
      for (g = 0; g < SESSION_SLOTS; g++) begin : g_cell
         stl_cell #(.Idx(g)) u_cell (
            .clock(clock),
            .reset(reset),
            .req(req_ff),
            .ctl(ctl),
            .tok_i(chain[g]),
            .tok_o(chain[g+1])
         );
      end
   endgenerate

   stl_div u_div (
      .clock(clock),
      .reset(reset),
      .start(div_start),
      .dividend(left + stl_pkg::RoundC),
      .done(div_done),
      .quotient(div_q)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         stl_pkg::StIdle:     if (start) state_in = stl_pkg::StDispatch;
         stl_pkg::StDispatch: begin
            if (launch.valid) state_in = stl_pkg::StScan;
            else if (div_start) state_in = stl_pkg::StDiv;
            else state_in = stl_pkg::StIdle;
         end
         stl_pkg::StScan:     if (tail.valid) state_in = stl_pkg::StIdle;
         stl_pkg::StDiv:      if (div_done) state_in = stl_pkg::StIdle;
         default:             state_in = stl_pkg::StIdle;
      endcase
   end

   always_comb begin
      launch           = '0;
      ctl              = '0;
      ctl.idle_timeout = idle_ff;
      ctl.abs_timeout  = abs_ff;
      div_start        = 1'b0;
      fail_in          = fail_ff;
      lu_in            = lu_ff;
      rsp_valid_in     = 1'b0;
      rsp_status_in    = stl_pkg::StatusUnauth;
      rsp_slot_in      = 1'b0;
      rsp_retry_in     = '0;
      rsp_ch_in        = '0;
      rsp_cl_in        = '0;
      case (state_ff)
         stl_pkg::StDispatch: begin
            case (kind_ff)
               stl_pkg::KindCheck, stl_pkg::KindCsrf, stl_pkg::KindLogout: begin
                  if (tok_ok_ff) begin
                     launch.valid  = 1'b1;
                     launch.mode   = stl_pkg::ModeFind;
                     launch.touch  = (kind_ff != stl_pkg::KindLogout);
                     launch.logout = (kind_ff == stl_pkg::KindLogout);
                  end else begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = (kind_ff == stl_pkg::KindLogout) ?
                                     stl_pkg::StatusOk : stl_pkg::StatusUnauth;
                  end
               end
               stl_pkg::KindLogin: begin
                  if (locked) begin
                     div_start = 1'b1;
                  end else if (!cred_ff) begin
                     if (fail_inc >= {24'd0, limit_ff}) begin
                        fail_in = '0;
                        lu_in   = lock_end;
                     end else begin
                        fail_in = fail_inc[7:0];
                     end
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = stl_pkg::StatusBadCred;
                  end else begin
                     fail_in      = '0;
                     lu_in        = '0;
                     launch.valid = 1'b1;
                     launch.mode  = stl_pkg::ModePick;
                  end
               end
               stl_pkg::KindInvAll: begin
                  ctl.clr_all   = 1'b1;
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = stl_pkg::StatusOk;
               end
               default: begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = stl_pkg::StatusUnauth;
               end
            endcase
         end
         stl_pkg::StScan: begin
            if (tail.valid) begin
               rsp_valid_in = 1'b1;
               if (tail.mode == stl_pkg::ModePick) begin
                  ctl.wr_en     = 1'b1;
                  ctl.wr_slot   = chosen;
                  rsp_status_in = stl_pkg::StatusOk;
                  rsp_slot_in   = chosen[0];
                  rsp_ch_in     = req_ff.csrf_high;
                  rsp_cl_in     = req_ff.csrf_low;
               end else if (kind_ff == stl_pkg::KindLogout) begin
                  rsp_status_in = stl_pkg::StatusOk;
                  rsp_slot_in   = tail.found && tail.found_slot[0];
               end else if (!tail.found) begin
                  rsp_status_in = stl_pkg::StatusUnauth;
               end else if ((kind_ff == stl_pkg::KindCsrf) && (!csrf_ok_ff ||
                            tail.csrf_high != req_ff.csrf_high ||
                            tail.csrf_low != req_ff.csrf_low)) begin
                  rsp_status_in = stl_pkg::StatusCsrfBad;
               end else begin
                  rsp_status_in = stl_pkg::StatusOk;
                  rsp_slot_in   = tail.found_slot[0];
                  rsp_ch_in     = tail.csrf_high;
                  rsp_cl_in     = tail.csrf_low;
               end
            end
         end
         stl_pkg::StDiv: begin
            if (div_done) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = stl_pkg::StatusLocked;
               rsp_retry_in  = div_q;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= stl_pkg::StIdle;
         rsp_valid_ff <= 1'b0;
         fail_ff      <= '0;
         lu_ff        <= '0;
         idle_ff      <= stl_pkg::IdleTimeoutReset;
         abs_ff       <= stl_pkg::AbsTimeoutReset;
         lock_dur_ff  <= stl_pkg::LockDurationReset;
         limit_ff     <= stl_pkg::FailureLimitReset;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         fail_ff      <= fail_in;
         lu_ff        <= lu_in;
         if (csr_valid) begin
            case (stl_pkg::csr_index_type'(csr_index))
               stl_pkg::CsrIdleTimeout:  idle_ff     <= csr_data;
               stl_pkg::CsrAbsTimeout:   abs_ff      <= csr_data;
               stl_pkg::CsrLockDuration: lock_dur_ff <= csr_data;
               stl_pkg::CsrFailureLimit: limit_ff    <= csr_data[7:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy) begin
         kind_ff           <= req_kind;
         req_ff.now        <= req_now;
         req_ff.addr       <= req_client_address;
         req_ff.token_high <= req_token_high;
         req_ff.token_low  <= req_token_low;
         req_ff.csrf_high  <= req_csrf_high;
         req_ff.csrf_low   <= req_csrf_low;
         tok_ok_ff         <= req_token_present;
         csrf_ok_ff        <= req_csrf_present;
         cred_ff           <= req_credentials_match;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_retry_ff  <= rsp_retry_in;
      rsp_ch_ff     <= rsp_ch_in;
      rsp_cl_ff     <= rsp_cl_in;
   end

   assign busy                  = (state_ff != stl_pkg::StIdle);
   assign csr_ready             = 1'b1;
   assign rsp_valid             = rsp_valid_ff;
   assign rsp_status            = rsp_status_ff;
   assign rsp_slot              = rsp_slot_ff;
   assign rsp_retry_seconds     = rsp_retry_ff;
   assign rsp_session_csrf_high = rsp_ch_ff;
   assign rsp_session_csrf_low  = rsp_cl_ff;

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (state_ff == stl_pkg::StIdle))
      else $error("result shown while a request is still in progress");

   a_tail_scan: assert property (@(posedge clock) disable iff (reset)
      tail.valid |-> (state_ff == stl_pkg::StScan))
      else $error("scan item left the chain outside the scan state");

   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == stl_pkg::StDiv))
      else $error("divider finished outside the lock state");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy && !rsp_valid))
      else $error("accepted item did not make the block busy");

endmodule

`default_nettype wire
